[hdl/qvr_pkg.sv]
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types, widths, register indexes and rounding for the quaternion
// vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int VEC_W     = 32;
  localparam int ROT_W     = 18;
  localparam int NORM_W    = 36;
  localparam int NUM_W     = 68;
  localparam int DIV_QW    = 33;
  localparam int DIV_BPS   = 3;
  localparam int DIV_ST    = DIV_QW / DIV_BPS;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_YZ     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALAR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;

  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    rot_t yz;
    rot_t zx;
    rot_t xy;
    rot_t s;
  } rotor_t;

  typedef struct packed {
    vec_t v;
    logic f;
  } sat_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    vec_t z;
    logic sat;
  } res_t;

  // round half up from Q.32 to Q.16, then clamp to 32 bits
  function automatic sat_t rnd_sat(input logic signed [63:0] acc);
    logic signed [63:0] y;
    sat_t r;
    y = (acc + 64'sd32768) >>> 16;
    if (y > 64'sd2147483647) begin
      r.v = 32'sh7fffffff;
      r.f = 1'b1;
    end else if (y < -64'sd2147483648) begin
      r.v = 32'sh80000000;
      r.f = 1'b1;
    end else begin
      r.v = y[VEC_W-1:0];
      r.f = 1'b0;
    end
    return r;
  endfunction

endpackage

[hdl/qvr_div.sv]
// ----------------------------------------------------------------------------
// qvr_div
// Pipelined restoring divider, a few quotient bits per stage, with a
// round-to-nearest flag from the final remainder.
// ----------------------------------------------------------------------------
module qvr_div (
  input  logic                             clk,
  input  logic [qvr_pkg::NUM_W-1:0]        num,
  input  logic [qvr_pkg::NORM_W-1:0]       den,
  output logic [qvr_pkg::DIV_QW-1:0]       quo,
  output logic                             rup
);

  logic [qvr_pkg::NORM_W-1:0] rem_r [qvr_pkg::DIV_ST];
  logic [qvr_pkg::DIV_QW-1:0] quo_r [qvr_pkg::DIV_ST];
  logic [qvr_pkg::DIV_QW-1:0] low_r [qvr_pkg::DIV_ST];

  for (genvar k = 0; k < qvr_pkg::DIV_ST; k++) begin : g_st
    logic [qvr_pkg::NORM_W-1:0] rem_i, rem_n;
    logic [qvr_pkg::DIV_QW-1:0] q_i, q_n, l_i, l_n;

    if (k == 0) begin : g_first
      // quotient is known to fit DIV_QW bits, so the top part is below den
      assign rem_i = qvr_pkg::NORM_W'(num[qvr_pkg::NUM_W-1:qvr_pkg::DIV_QW]);
      assign q_i   = '0;
      assign l_i   = num[qvr_pkg::DIV_QW-1:0];
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign q_i   = quo_r[k-1];
      assign l_i   = low_r[k-1];
    end

    always_comb begin
      logic [qvr_pkg::NORM_W:0] r;
      rem_n = rem_i;
      q_n   = q_i;
      l_n   = l_i;
      r     = '0;
      for (int j = 0; j < qvr_pkg::DIV_BPS; j++) begin
        r   = {rem_n, l_n[qvr_pkg::DIV_QW-1]};
        l_n = l_n << 1;
        if (r >= {1'b0, den}) begin
          r   = r - {1'b0, den};
          q_n = {q_n[qvr_pkg::DIV_QW-2:0], 1'b1};
        end else begin
          q_n = {q_n[qvr_pkg::DIV_QW-2:0], 1'b0};
        end
        rem_n = r[qvr_pkg::NORM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_n;
      quo_r[k] <= q_n;
      low_r[k] <= l_n;
    end
  end

  assign quo = quo_r[qvr_pkg::DIV_ST-1];
  assign rup = {rem_r[qvr_pkg::DIV_ST-1], 1'b0} >= {1'b0, den};

endmodule

[hdl/qvr_full.sv]
// ----------------------------------------------------------------------------
// qvr_full
// Full rotation pipeline: t = 2(v x n), v' = v + s*t + t x n.
// Five register stages.
// ----------------------------------------------------------------------------
module qvr_full (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  qvr_pkg::vec_t    vx,
  input  qvr_pkg::vec_t    vy,
  input  qvr_pkg::vec_t    vz,
  input  qvr_pkg::rotor_t  rotor,
  output logic             out_valid,
  output qvr_pkg::res_t    res
);

  qvr_pkg::rot_t n [3];
  qvr_pkg::vec_t vin [3];
  qvr_pkg::vec_t v1 [3], v2 [3], v3 [3];
  logic signed [49:0] ca [3], cb [3];
  logic signed [39:0] t [3];
  logic signed [57:0] st [3], xa [3], xb [3];
  logic signed [63:0] acc [3];
  qvr_pkg::sat_t rs [3];
  logic val1, val2, val3, val4;

  assign n[0]   = rotor.yz;
  assign n[1]   = rotor.zx;
  assign n[2]   = rotor.xy;
  assign vin[0] = vx;
  assign vin[1] = vy;
  assign vin[2] = vz;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic signed [63:0] dif, tn;

    always_comb begin
      dif = 64'(ca[i]) - 64'(cb[i]);
      tn  = ((dif <<< 1) + 64'sd32768) >>> 16;
    end

    assign rs[i] = qvr_pkg::rnd_sat(acc[i]);

    always_ff @(posedge clk) begin
      ca[i]  <= vin[J] * n[K];
      cb[i]  <= vin[K] * n[J];
      v1[i]  <= vin[i];
      t[i]   <= tn[39:0];
      v2[i]  <= v1[i];
      st[i]  <= rotor.s * t[i];
      xa[i]  <= t[J] * n[K];
      xb[i]  <= t[K] * n[J];
      v3[i]  <= v2[i];
      acc[i] <= (64'(v3[i]) <<< 16) + 64'(st[i]) + 64'(xa[i]) - 64'(xb[i]);
    end
  end

  always_ff @(posedge clk) begin
    res.x   <= rs[0].v;
    res.y   <= rs[1].v;
    res.z   <= rs[2].v;
    res.sat <= rs[0].f | rs[1].f | rs[2].f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val1      <= 1'b0;
      val2      <= 1'b0;
      val3      <= 1'b0;
      val4      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      val1      <= in_valid;
      val2      <= val1;
      val3      <= val2;
      val4      <= val3;
      out_valid <= val4;
    end
  end

endmodule

[hdl/qvr_half.sv]
// ----------------------------------------------------------------------------
// qvr_half
// Half rotation pipeline: projection on n through a pipelined divider,
// rotor applied to the in-plane part, projection added back.
// ----------------------------------------------------------------------------
module qvr_half (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  qvr_pkg::vec_t                vx,
  input  qvr_pkg::vec_t                vy,
  input  qvr_pkg::vec_t                vz,
  input  qvr_pkg::rotor_t              rotor,
  input  logic [qvr_pkg::NORM_W-1:0]   norm,
  output logic                         out_valid,
  output qvr_pkg::res_t                res
);

  typedef struct packed {
    qvr_pkg::vec_t x;
    qvr_pkg::vec_t y;
    qvr_pkg::vec_t z;
    logic [2:0]    neg;
    logic          zero;
    logic          val;
  } side_t;

  qvr_pkg::rot_t n [3];
  qvr_pkg::vec_t vin [3];
  qvr_pkg::vec_t v1 [3], v2 [3], v3 [3];
  logic signed [49:0] dp [3];
  logic signed [51:0] dot;
  logic [43:0] lo [3];
  logic [42:0] hi [3];
  logic [2:0]  neg3;
  logic        zero3;
  logic        val1, val2, val3;
  logic [qvr_pkg::NUM_W-1:0]  num [3];
  logic [qvr_pkg::DIV_QW-1:0] quo [3];
  logic        rup [3];
  side_t       sd [qvr_pkg::DIV_ST+1];
  side_t       s5, s6, s7, s8;
  logic signed [34:0] p5 [3], p6 [3], p7 [3];
  logic signed [35:0] o6 [3];
  logic signed [53:0] ma [3], mb [3], ms [3];
  logic signed [63:0] acc [3];
  qvr_pkg::sat_t rs [3];
  qvr_pkg::vec_t v8 [3];
  logic [50:0] adot;

  assign n[0]   = rotor.yz;
  assign n[1]   = rotor.zx;
  assign n[2]   = rotor.xy;
  assign vin[0] = vx;
  assign vin[1] = vy;
  assign vin[2] = vz;

  assign adot = dot[51] ? 51'(-dot) : dot[50:0];

  always_ff @(posedge clk) begin
    dot   <= 52'(dp[0]) + 52'(dp[1]) + 52'(dp[2]);
    zero3 <= (norm == '0);
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic [17:0] an;
    logic [68:0] nsum;
    logic [33:0] pm;
    logic signed [34:0] ps;

    assign an   = n[i][17] ? 18'(-n[i]) : n[i];
    assign nsum = {25'b0, lo[i]} + {hi[i], 26'b0};
    assign pm   = {1'b0, quo[i]} + {33'b0, rup[i]};
    assign ps   = $signed({1'b0, pm});
    assign rs[i] = qvr_pkg::rnd_sat(acc[i]);

    qvr_div u_div (
      .clk (clk),
      .num (num[i]),
      .den (norm),
      .quo (quo[i]),
      .rup (rup[i])
    );

    always_ff @(posedge clk) begin
      dp[i]   <= vin[i] * n[i];
      v1[i]   <= vin[i];
      v2[i]   <= v1[i];
      lo[i]   <= an * adot[25:0];
      hi[i]   <= an * adot[50:26];
      neg3[i] <= n[i][17] ^ dot[51];
      v3[i]   <= v2[i];
      num[i]  <= nsum[qvr_pkg::NUM_W-1:0];
      p5[i]   <= sd[qvr_pkg::DIV_ST].neg[i] ? -ps : ps;
      p6[i]   <= p5[i];
      o6[i]   <= 36'(v8[i]) - 36'(p5[i]);
      p7[i]   <= p6[i];
      ma[i]   <= o6[J] * n[K];
      mb[i]   <= o6[K] * n[J];
      ms[i]   <= rotor.s * o6[i];
      acc[i]  <= 64'(ma[i]) - 64'(mb[i]) + 64'(ms[i]) + (64'(p7[i]) <<< 16);
    end
  end

  // stage-5 input vector comes from the side line at the divider output
  assign v8[0] = s5.x;
  assign v8[1] = s5.y;
  assign v8[2] = s5.z;

  // side words ride along the divider stages; only the valid bits reset
  always_ff @(posedge clk) begin
    sd[0].x    <= v3[0];
    sd[0].y    <= v3[1];
    sd[0].z    <= v3[2];
    sd[0].neg  <= neg3;
    sd[0].zero <= zero3;
    for (int k = 1; k <= qvr_pkg::DIV_ST; k++) begin
      sd[k].x    <= sd[k-1].x;
      sd[k].y    <= sd[k-1].y;
      sd[k].z    <= sd[k-1].z;
      sd[k].neg  <= sd[k-1].neg;
      sd[k].zero <= sd[k-1].zero;
    end
    s5.x    <= sd[qvr_pkg::DIV_ST].x;
    s5.y    <= sd[qvr_pkg::DIV_ST].y;
    s5.z    <= sd[qvr_pkg::DIV_ST].z;
    s5.neg  <= sd[qvr_pkg::DIV_ST].neg;
    s5.zero <= sd[qvr_pkg::DIV_ST].zero;
    {s6.x, s6.y, s6.z, s6.neg, s6.zero} <= {s5.x, s5.y, s5.z, s5.neg, s5.zero};
    {s7.x, s7.y, s7.z, s7.neg, s7.zero} <= {s6.x, s6.y, s6.z, s6.neg, s6.zero};
    {s8.x, s8.y, s8.z, s8.neg, s8.zero} <= {s7.x, s7.y, s7.z, s7.neg, s7.zero};
    if (s8.zero) begin
      res.x   <= s8.x;
      res.y   <= s8.y;
      res.z   <= s8.z;
      res.sat <= 1'b0;
    end else begin
      res.x   <= rs[0].v;
      res.y   <= rs[1].v;
      res.z   <= rs[2].v;
      res.sat <= rs[0].f | rs[1].f | rs[2].f;
    end
    if (rst) begin
      for (int k = 0; k <= qvr_pkg::DIV_ST; k++) begin
        sd[k].val <= 1'b0;
      end
      s5.val <= 1'b0;
      s6.val <= 1'b0;
      s7.val <= 1'b0;
      s8.val <= 1'b0;
    end else begin
      sd[0].val <= val3;
      for (int k = 1; k <= qvr_pkg::DIV_ST; k++) begin
        sd[k].val <= sd[k-1].val;
      end
      s5.val <= sd[qvr_pkg::DIV_ST].val;
      s6.val <= s5.val;
      s7.val <= s6.val;
      s8.val <= s7.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val1      <= 1'b0;
      val2      <= 1'b0;
      val3      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      val1      <= in_valid;
      val2      <= val1;
      val3      <= val2;
      out_valid <= s8.val;
    end
  end

endmodule

[hdl/quaternion_vector_rotate.sv]
// Full rotation mode uses the qvr_full pipe; half rotation mode uses qvr_half, whose
// projection divider retires 3 quotient bits per stage.
// Throughput: one word per cycle in either mode; busy is never raised.
// Results leave on a one-cycle done strobe; the receiver cannot stall.
// Reset clears the pipeline valid bits, selects full rotation and loads the rotor with the identity (s = 1.0).
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates Q15.16 vectors by a configured Q1.16 rotor, full or half rotation,
// with saturation of each component.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                vec_x,
  input  logic signed [31:0]                vec_y,
  input  logic signed [31:0]                vec_z,
  output logic                              done,
  output logic signed [31:0]                rot_x,
  output logic signed [31:0]                rot_y,
  output logic signed [31:0]                rot_z,
  output logic                              saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [17:0]                       cfg_data
);

  qvr_pkg::rotor_t rotor;
  logic            mode;
  logic [qvr_pkg::NORM_W-1:0] norm;
  logic signed [35:0] sq0, sq1, sq2;
  logic            accept;
  logic            full_done, half_done;
  qvr_pkg::res_t   full_res, half_res, res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  assign sq0 = rotor.yz * rotor.yz;
  assign sq1 = rotor.zx * rotor.zx;
  assign sq2 = rotor.xy * rotor.xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotor.yz <= '0;
      rotor.zx <= '0;
      rotor.xy <= '0;
      rotor.s  <= 18'sd65536;
      mode     <= 1'b0;
      norm     <= '0;
    end else begin
      norm <= $unsigned(sq0) + $unsigned(sq1) + $unsigned(sq2);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          qvr_pkg::REG_YZ:     rotor.yz <= cfg_data;
          qvr_pkg::REG_ZX:     rotor.zx <= cfg_data;
          qvr_pkg::REG_XY:     rotor.xy <= cfg_data;
          qvr_pkg::REG_SCALAR: rotor.s  <= cfg_data;
          qvr_pkg::REG_MODE:   mode     <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  qvr_full u_full (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept & ~mode),
    .vx        (vec_x),
    .vy        (vec_y),
    .vz        (vec_z),
    .rotor     (rotor),
    .out_valid (full_done),
    .res       (full_res)
  );

  qvr_half u_half (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept & mode),
    .vx        (vec_x),
    .vy        (vec_y),
    .vz        (vec_z),
    .rotor     (rotor),
    .norm      (norm),
    .out_valid (half_done),
    .res       (half_res)
  );

  // user must change mode only while idle (the block does not enforce it), so the two pipes never finish together
  assign res       = half_done ? half_res : full_res;
  assign done      = full_done | half_done;
  assign rot_x     = res.x;
  assign rot_y     = res.y;
  assign rot_z     = res.z;
  assign saturated = res.sat;

`ifndef SYNTH
  a_one_pipe: assert property (@(posedge clk) disable iff (rst)
    !(full_done && half_done))
    else $error("both pipelines finished in one cycle");

  a_full_lat: assert property (@(posedge clk) disable iff (rst)
    full_done |-> $past(start, 5))
    else $error("full rotation word without matching start");

  a_half_lat: assert property (@(posedge clk) disable iff (rst)
    half_done |-> $past(start, 20))
    else $error("half rotation word without matching start");
`endif

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion vector rotator. Vectors go in through
// the start/busy handshake and rotor registers through the config channel. An
// in-bench predictor computes each rotated word in both rotation modes. Every
// done strobe is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [qvr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;

  class rotation_scoreboard;
    longint yz, zx, xy, sc, norm_sq;
    bit half_mode;
    qvr_pkg::res_t pending[$];
    int mismatches, words_checked;

    function new();
      yz = 0; zx = 0; xy = 0; sc = 65536; half_mode = 0; norm_sq = 0;
    endfunction

    function void write_reg(logic [qvr_pkg::CFG_IDX_W-1:0] idx, logic [17:0] data);
      case (idx)
        qvr_pkg::REG_YZ:     yz = longint'(qvr_pkg::rot_t'(data));
        qvr_pkg::REG_ZX:     zx = longint'(qvr_pkg::rot_t'(data));
        qvr_pkg::REG_XY:     xy = longint'(qvr_pkg::rot_t'(data));
        qvr_pkg::REG_SCALAR: sc = longint'(qvr_pkg::rot_t'(data));
        qvr_pkg::REG_MODE:   half_mode = data[0];
        default:             return;
      endcase
      norm_sq = yz * yz + zx * zx + xy * xy;
    endfunction

    function longint clamp(longint a, inout bit f);
      longint y;
      y = a >>> 16;  // scale from Q.32 to Q.16; callers add the half for rounding
      if (y > 64'sd2147483647) begin
        f = 1; return 64'sd2147483647;
      end
      if (y < -64'sd2147483648) begin
        f = 1; return -64'sd2147483648;
      end
      return y;
    endfunction

    // round(a*b/d) on the magnitude, ties away from zero
    function longint project(longint a, longint b);
      logic [63:0] ua, ub;
      logic [127:0] prod, q, rem, d;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      prod = {64'd0, ua} * {64'd0, ub};
      d = {64'd0, norm_sq};
      q = prod / d;
      rem = prod % d;
      if ((rem << 1) >= d) q = q + 1;
      return neg ? -longint'({18'd0, q[45:0]}) : longint'({18'd0, q[45:0]});
    endfunction

    function void note_vector(qvr_pkg::vec_t x, qvr_pkg::vec_t y, qvr_pkg::vec_t z);
      longint v[3], n[3], t[3], p[3], o[3], acc[3], r[3], dot;
      bit f;
      qvr_pkg::res_t e;
      f = 0;
      v[0] = x; v[1] = y; v[2] = z;
      n[0] = yz; n[1] = zx; n[2] = xy;
      if (!half_mode) begin
        t[0] = (2 * (v[1] * n[2] - v[2] * n[1]) + 32768) >>> 16;
        t[1] = (2 * (v[2] * n[0] - v[0] * n[2]) + 32768) >>> 16;
        t[2] = (2 * (v[0] * n[1] - v[1] * n[0]) + 32768) >>> 16;
        acc[0] = v[0] * 65536 + sc * t[0] + (t[1] * n[2] - t[2] * n[1]);
        acc[1] = v[1] * 65536 + sc * t[1] + (t[2] * n[0] - t[0] * n[2]);
        acc[2] = v[2] * 65536 + sc * t[2] + (t[0] * n[1] - t[1] * n[0]);
        for (int i = 0; i < 3; i++) r[i] = clamp(acc[i] + 32768, f);
      end else if (norm_sq == 0) begin
        for (int i = 0; i < 3; i++) r[i] = v[i];
      end else begin
        dot = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
        for (int i = 0; i < 3; i++) begin
          p[i] = project(n[i], dot);
          o[i] = v[i] - p[i];
        end
        acc[0] = n[2] * o[1] - n[1] * o[2] + sc * o[0];
        acc[1] = n[0] * o[2] - n[2] * o[0] + sc * o[1];
        acc[2] = n[1] * o[0] - n[0] * o[1] + sc * o[2];
        for (int i = 0; i < 3; i++) r[i] = clamp(acc[i] + p[i] * 65536 + 32768, f);
      end
      e.x = r[0][31:0]; e.y = r[1][31:0]; e.z = r[2][31:0]; e.sat = f;
      pending.push_back(e);
    endfunction

    function void check_word(qvr_pkg::res_t got);
      qvr_pkg::res_t e;
      words_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h %h %h sat=%b",
                                       got.x, got.y, got.z, got.sat);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h %h %h sat=%b, got %h %h %h sat=%b",
                   e.x, e.y, e.z, e.sat, got.x, got.y, got.z, got.sat);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  qvr_pkg::vec_t vec_x = '0, vec_y = '0, vec_z = '0;
  logic done, saturated;
  qvr_pkg::vec_t rot_x, rot_y, rot_z;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [qvr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;

  rotation_scoreboard sb = new();
  int cycles = 0;
  int idle_pct = 0;
  int sent = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  quaternion_vector_rotate DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_vector(vec_x, vec_y, vec_z);
      if (done) sb.check_word({rot_x, rot_y, rot_z, saturated});
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_vector(qvr_pkg::vec_t x, qvr_pkg::vec_t y, qvr_pkg::vec_t z);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1;
    vec_x <= x; vec_y <= y; vec_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // pipeline empty: nothing pending plus the half-mode latency
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_word(logic [qvr_pkg::CFG_IDX_W-1:0] idx, logic [17:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_rotor(logic [17:0] a, logic [17:0] b, logic [17:0] c,
                           logic [17:0] s, logic m);
    drain();
    cfg_word(qvr_pkg::REG_YZ, a);
    cfg_word(qvr_pkg::REG_ZX, b);
    cfg_word(qvr_pkg::REG_XY, c);
    cfg_word(qvr_pkg::REG_SCALAR, s);
    cfg_word(qvr_pkg::REG_MODE, {17'($urandom_range(131071)), m});
    cfg_word(REG_UNUSED, 18'($urandom));  // must be ignored
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic qvr_pkg::vec_t rand_comp();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2:       return qvr_pkg::vec_t'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
      default: return qvr_pkg::vec_t'($signed($urandom) >>> $urandom_range(14, 4));
    endcase
  endfunction

  function automatic logic [17:0] rand_rotor();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 18'h1ffff : 18'h20000;
      1:       return 18'($urandom);
      default: return 18'($signed(18'($urandom)) >>> 1);
    endcase
  endfunction

  task automatic directed_block();
    send_vector(0, 0, 0);
    send_vector(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_vector(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vector(32'sh7fffffff, 32'sh80000000, 32'sh00010000);
    send_vector(32'sh00010000, 32'sh00008000, -32'sh00008000);
    send_vector(32'shffffffff, 32'sh00000001, 32'sh55555555);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      send_vector(rand_comp(), rand_comp(), rand_comp());
      if (i == count / 2) drain();  // let every word out mid-phase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // identity rotor out of reset, then the extremes of each register and a unit rotor
    directed_block();
    set_rotor(18'h1ffff, 18'h20000, 18'h1ffff, 18'h20000, 0);
    directed_block();
    set_rotor(18'h08000, 18'h00000, 18'h00000, 18'h0ddb4, 0);
    directed_block();
    // half rotation with zero axis passes the vector through
    set_rotor(0, 0, 0, 18'h1ffff, 1);
    directed_block();
    set_rotor(18'h20000, 18'h1ffff, 18'h00001, 18'h20000, 1);
    directed_block();

    for (int ph = 0; ph < 18; ph++) begin
      idle_pct = ph < 6 ? 20 : (ph < 12 ? 51 : 0);
      if (ph % 6 == 5)
        set_rotor(0, 0, 0, rand_rotor(), 1'(ph % 2));
      else
        set_rotor(rand_rotor(), rand_rotor(), rand_rotor(), rand_rotor(), 1'(ph % 2));
      random_phase(84);
    end
    drain();

    $display("covered %0d vectors, %0d words checked, both modes, rotor extremes",
             sent, sb.words_checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d words never arrived", sb.mismatches,
               sb.pending.size());
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[quaternion_vector_rotate.f]
hdl/qvr_pkg.sv
hdl/qvr_div.sv
hdl/qvr_full.sv
hdl/qvr_half.sv
hdl/quaternion_vector_rotate.sv
test/tb_top.sv
